### design/lpht_pkg.sv
// shared constants and types for the linear probe hash table
`default_nettype none
package lpht_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam logic [31:0] DJB_SEED = 32'd5381;
    localparam logic [CNT_W-1:0] FULL_LIMIT = CNT_W'((TABLE_DEPTH * 3) / 4);

    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [5:0]       slot;
        logic [VAL_W-1:0] value_out;
    } rsp_t;
endpackage
`default_nettype wire

### design/lpht_if.sv
// valid/ready channel interfaces for request and response words
`default_nettype none
interface lpht_req_if;
    logic              valid;
    logic              ready;
    lpht_pkg::req_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lpht_rsp_if;
    logic              valid;
    logic              ready;
    lpht_pkg::rsp_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/lpht_hash.sv
// iterative djb hash, one key byte per cycle through one multiply-add
`default_nettype none
module lpht_hash (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lpht_pkg::KEY_W-1:0] key,
    output logic                            done,
    output logic [31:0]                     hash
);
    import lpht_pkg::*;

    logic [31:0] h_reg, h_next;
    logic [KEY_W-1:0] k_reg;
    logic [2:0] n_reg;
    logic busy_reg;

    // h*33 is a shift and an add
    assign h_next = (h_reg << 5) + h_reg + {24'd0, k_reg[7:0]};
    assign hash = h_reg;
    assign done = busy_reg && (n_reg == 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg    <= 3'(KEY_W / 8);
            h_reg    <= DJB_SEED;
            k_reg    <= key;
        end
        else if (busy_reg)
        begin
            if (n_reg == 3'd0)
                busy_reg <= 1'b0;
            else
            begin
                h_reg <= h_next;
                k_reg <= k_reg >> 8;
                n_reg <= n_reg - 3'd1;
            end
        end
    end
endmodule
`default_nettype wire

### design/linear_probe_hash_table.sv
// linear probe hash table top level with probe and delete-shift sequencer
//  channel | dir | fields
//  req     | in  | mode, key, value
//  rsp     | out | status, slot, value_out
//  cfg     | in  | cfg_we, cfg_data (hash_mode)
// one word at a time: hash_mode 1 hashes the key first, hash_mode 0 probes at once;
// then one slot visited per cycle, set by the registered read of the slot store.
// a delete looks at each entry past the hole in S_SHIFT, then S_SHASH, which waits for the hash in hash_mode 1.
// reset clears used bits and the count at once; hash_mode resets to 1.
// the response waits in its register until taken; no new word meanwhile.
`default_nettype none
module linear_probe_hash_table (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_data,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp
);
    import lpht_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_HASH, S_PROBE, S_SHIFT, S_SHASH, S_RESP} state_t;

    state_t state_reg;
    logic mode_cfg_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [KEY_W-1:0] mem_key [TABLE_DEPTH];
    logic [VAL_W-1:0] mem_val [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    req_t op_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic [IDX_W-1:0] idx_reg, cur_reg;
    logic [CNT_W-1:0] n_reg;
    logic [KEY_W-1:0] nkey_reg;
    logic [VAL_W-1:0] nval_reg;
    logic [KEY_W-1:0] rkey_reg;
    logic [VAL_W-1:0] rval_reg;

    logic hstart, hdone;
    logic [KEY_W-1:0] hkey;
    logic [31:0] hval;

    lpht_hash u_hash (.clk(clk), .rst_n(rst_n), .start(hstart), .key(hkey),
                      .done(hdone), .hash(hval));

    logic [KEY_W-1:0] skey;
    logic [VAL_W-1:0] sval;
    logic [IDX_W-1:0] nxt;
    logic match;
    logic [IDX_W-1:0] home_n;
    logic [IDX_W-1:0] rd_addr;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [KEY_W-1:0] mem_wkey;
    logic [VAL_W-1:0] mem_wval;

    assign skey = rkey_reg;
    assign sval = rval_reg;
    assign nxt  = cur_reg + 1'b1;
    assign match = mode_cfg_reg ? (skey == op_reg.key) : (skey[7:0] == op_reg.key[7:0]);
    assign home_n = mode_cfg_reg ? hval[IDX_W-1:0] : IDX_W'(nkey_reg[7:0]);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // read address is the slot that the next probe or shift step looks at
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = IDX_W'(req.data.key[7:0]);
            S_HASH:  rd_addr = hval[IDX_W-1:0];
            S_PROBE: rd_addr = idx_reg + 1'b1;
            default: rd_addr = cur_reg + IDX_W'(2);
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wkey  = op_reg.key;
        mem_wval  = op_reg.value;
        if (state_reg == S_PROBE && n_reg != CNT_W'(TABLE_DEPTH) && op_reg.mode == OP_PUT
            && (!used_reg[idx_reg] || match))
            mem_we = 1'b1;
        else if (state_reg == S_SHASH && (!mode_cfg_reg || hdone) && home_n != nxt)
        begin
            mem_we    = 1'b1;
            mem_waddr = cur_reg;
            mem_wkey  = nkey_reg;
            mem_wval  = nval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_key[mem_waddr] <= mem_wkey;
            mem_val[mem_waddr] <= mem_wval;
        end
        rkey_reg <= mem_key[rd_addr];
        rval_reg <= mem_val[rd_addr];
    end

    always_comb
    begin
        hstart = 1'b0;
        hkey   = op_reg.key;
        if (state_reg == S_IDLE && req.valid && mode_cfg_reg)
        begin
            hstart = 1'b1;
            hkey   = req.data.key;
        end
        else if (state_reg == S_SHIFT && used_reg[nxt] && mode_cfg_reg)
        begin
            hstart = 1'b1;
            hkey   = rkey_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_cfg_reg  <= 1'b1;
            used_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_cfg_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg <= req.data;
                        n_reg  <= '0;
                        idx_reg <= IDX_W'(req.data.key[7:0]);
                        if (req.data.mode == OP_PUT && count_reg >= FULL_LIMIT)
                        begin
                            rsp_reg   <= '{ST_FULL, 6'd0, '0};
                            state_reg <= S_RESP;
                            rsp_valid_reg <= 1'b1;
                        end
                        else if (req.data.mode != OP_PUT && req.data.mode != OP_GET
                                 && req.data.mode != OP_DEL)
                        begin
                            rsp_reg   <= '{ST_NOT_FOUND, 6'd0, '0};
                            state_reg <= S_RESP;
                            rsp_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= mode_cfg_reg ? S_HASH : S_PROBE;
                    end
                end
                S_HASH:
                begin
                    if (hdone)
                    begin
                        idx_reg   <= hval[IDX_W-1:0];
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (n_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        rsp_reg <= '{(op_reg.mode == OP_PUT) ? ST_FULL : ST_NOT_FOUND,
                                     6'd0, '0};
                        state_reg <= S_RESP;
                        rsp_valid_reg <= 1'b1;
                    end
                    else if (!used_reg[idx_reg])
                    begin
                        if (op_reg.mode == OP_PUT)
                        begin
                            used_reg[idx_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                            rsp_reg <= '{ST_INSERTED, 6'(idx_reg), '0};
                        end
                        else
                            rsp_reg <= '{ST_NOT_FOUND, 6'd0, '0};
                        state_reg <= S_RESP;
                        rsp_valid_reg <= 1'b1;
                    end
                    else if (match)
                    begin
                        case (op_reg.mode)
                            OP_PUT:
                            begin
                                rsp_reg <= '{ST_UPDATED, 6'(idx_reg), '0};
                                state_reg <= S_RESP;
                                rsp_valid_reg <= 1'b1;
                            end
                            OP_GET:
                            begin
                                rsp_reg <= '{ST_FOUND, 6'(idx_reg), sval};
                                state_reg <= S_RESP;
                                rsp_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                                rsp_reg <= '{ST_DELETED, 6'(idx_reg), '0};
                                used_reg[idx_reg] <= 1'b0;
                                count_reg <= count_reg - 1'b1;
                                cur_reg <= idx_reg;
                                n_reg <= CNT_W'(1);
                                state_reg <= S_SHIFT;
                            end
                        endcase
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        n_reg   <= n_reg + 1'b1;
                    end
                end
                S_SHIFT:
                begin
                    // look at the entry after the hole
                    nkey_reg <= rkey_reg;
                    nval_reg <= rval_reg;
                    if (n_reg == CNT_W'(TABLE_DEPTH) || !used_reg[nxt])
                    begin
                        state_reg <= S_RESP;
                        rsp_valid_reg <= 1'b1;
                    end
                    else
                        state_reg <= S_SHASH;
                end
                S_SHASH:
                begin
                    if (!mode_cfg_reg || hdone)
                    begin
                        if (home_n == nxt)
                        begin
                            state_reg <= S_RESP;
                            rsp_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            used_reg[cur_reg] <= 1'b1;
                            used_reg[nxt]     <= 1'b0;
                            cur_reg <= nxt;
                            n_reg   <= n_reg + 1'b1;
                            state_reg <= S_SHIFT;
                        end
                    end
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/lpht_checker.sv
// port-level checks for the hash table, bound to the top level
`default_nettype none
module lpht_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic [2:0] status,
    input wire logic [5:0] slot,
    input wire logic [31:0] value_out
);
    import lpht_pkg::*;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("request taken with response pending");
    a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_FOUND |-> value_out == '0) else $error("stray value");
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> slot == '0)
        else $error("stray slot");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
        else $error("response dropped");
endmodule

bind linear_probe_hash_table lpht_checker u_chk (
    .clk(clk), .rst_n(rst_n), .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.data.status),
    .slot(rsp.data.slot), .value_out(rsp.data.value_out));
`default_nettype wire

### tb/linear_probe_hash_table_tb.sv
// self-checking testbench for the linear probe hash table
`timescale 1ns / 100ps
`default_nettype none
module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();

    linear_probe_hash_table DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch.sink),
        .rsp      (rsp_ch.source)
    );

    // shadow table
    bit              tbl_used [TABLE_DEPTH];
    bit [KEY_W-1:0]  tbl_key  [TABLE_DEPTH];
    bit [VAL_W-1:0]  tbl_val  [TABLE_DEPTH];
    int              tbl_count;
    bit              hash_sel;

    rsp_t            pending_rsp [$];
    bit [KEY_W-1:0]  known_keys [$];
    int              mismatches;
    int              cycle_count;
    bit              sender_idle_on;
    bit              receiver_idle_on;
    int              hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit [IDX_W-1:0] home_slot(bit [KEY_W-1:0] k);
        bit [31:0] h;
        if (!hash_sel)
            return k[IDX_W-1:0];
        h = DJB_SEED;
        for (int i = 0; i < KEY_W / 8; i++)
            h = h * 32'd33 + {24'd0, k[8*i +: 8]};
        return h[IDX_W-1:0];
    endfunction

    function automatic bit same_key(bit [KEY_W-1:0] a, bit [KEY_W-1:0] b);
        return hash_sel ? (a == b) : (a[7:0] == b[7:0]);
    endfunction

    function automatic rsp_t table_apply(req_t w);
        rsp_t r;
        bit [IDX_W-1:0] idx;
        bit [IDX_W-1:0] cur;
        bit [IDX_W-1:0] nxt;
        r.status = ST_NOT_FOUND;
        r.slot = '0;
        r.value_out = '0;
        idx = home_slot(w.key);
        if (w.mode == OP_PUT)
        begin
            r.status = ST_FULL;
            if (tbl_count * 4 < TABLE_DEPTH * 3)
            begin
                for (int n = 0; n < TABLE_DEPTH; n++)
                begin
                    if (!tbl_used[idx] || same_key(tbl_key[idx], w.key))
                    begin
                        r.status = tbl_used[idx] ? ST_UPDATED : ST_INSERTED;
                        if (!tbl_used[idx])
                            tbl_count++;
                        tbl_used[idx] = 1'b1;
                        tbl_key[idx] = w.key;
                        tbl_val[idx] = w.value;
                        r.slot = idx;
                        break;
                    end
                    idx = idx + 1'b1;
                end
            end
        end
        else if (w.mode == OP_GET || w.mode == OP_DEL)
        begin
            for (int n = 0; n < TABLE_DEPTH && tbl_used[idx]; n++)
            begin
                if (same_key(tbl_key[idx], w.key))
                begin
                    r.slot = idx;
                    if (w.mode == OP_GET)
                    begin
                        r.status = ST_FOUND;
                        r.value_out = tbl_val[idx];
                        break;
                    end
                    r.status = ST_DELETED;
                    tbl_used[idx] = 1'b0;
                    tbl_count--;
                    cur = idx;
                    // pull the cluster back until an empty slot or a home entry
                    for (int m = 1; m < TABLE_DEPTH; m++)
                    begin
                        nxt = cur + 1'b1;
                        if (!tbl_used[nxt] || home_slot(tbl_key[nxt]) == nxt)
                            break;
                        tbl_used[cur] = 1'b1;
                        tbl_key[cur] = tbl_key[nxt];
                        tbl_val[cur] = tbl_val[nxt];
                        tbl_used[nxt] = 1'b0;
                        cur = nxt;
                    end
                    break;
                end
                idx = idx + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic bit idle_roll(bit enabled);
        return enabled && ($urandom_range(99) < 27);
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[linear_probe_hash_table] ERROR");
            $finish;
        end
    end

    // response side: ready driven at falling edge
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp_ch.ready <= !idle_roll(receiver_idle_on);
    end

    always @(posedge clk)
    begin
        rsp_t exp_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word status=%0d slot=%0d value=%h",
                             rsp_ch.data.status, rsp_ch.data.slot, rsp_ch.data.value_out);
            end
            else
            begin
                exp_w = pending_rsp.pop_front();
                if (rsp_ch.data !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d sl=%0d v=%h got st=%0d sl=%0d v=%h",
                                 exp_w.status, exp_w.slot, exp_w.value_out,
                                 rsp_ch.data.status, rsp_ch.data.slot,
                                 rsp_ch.data.value_out);
                end
            end
        end
    end

    // valid stays up after an accepted word; the next word or an idle cycle replaces it
    task automatic send_word(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        req_t w;
        w.mode = op;
        w.key = k;
        w.value = v;
        while (idle_roll(sender_idle_on))
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_rsp.push_back(table_apply(w));
        if (op == OP_PUT)
            known_keys.push_back(k);
        @(negedge clk);
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_hash_mode(bit m);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        hash_sel = m;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(99) < 60)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        // half the new keys take one of 16 low bytes so clusters and collisions form
        if ($urandom_range(1))
            return {24'($urandom()), 8'($urandom_range(15))};
        return $urandom();
    endfunction

    task automatic random_ops(int n, int put_pct);
        int r;
        logic [1:0] op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < put_pct)
                op = OP_PUT;
            else if (r < put_pct + (100 - put_pct) / 2)
                op = OP_GET;
            else if (r < 98)
                op = OP_DEL;
            else
                op = 2'd3;
            send_word(op, pick_key(), $urandom());
        end
    endtask

    task automatic test_directed;
        send_word(OP_GET, 32'h0, 32'h0);
        send_word(OP_DEL, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_PUT, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_PUT, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_PUT, 32'h0, 32'h1234_5678);
        send_word(OP_GET, 32'h0, 32'h0);
        send_word(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_DEL, 32'h0, 32'h0);
        send_word(OP_GET, 32'h0, 32'h0);
        send_word(OP_GET, 32'hFFFF_FFFF, 32'h0);
    endtask

    // low-byte mode: colliding keys, delete shifting, fill to refusal, then random operations
    task automatic test_low_byte_mode;
        write_hash_mode(1'b0);
        for (int i = 0; i < 6; i++)
            send_word(OP_PUT, {24'($urandom()), 8'h3E}, $urandom());
        send_word(OP_PUT, 32'h0000_003F, 32'hA5A5_A5A5);
        send_word(OP_DEL, 32'h0000_003E, 32'h0);
        send_word(OP_GET, 32'h0000_003F, 32'h0);
        send_word(OP_PUT, 32'hABCD_EF3E, 32'h1);
        for (int i = 0; i < 70; i++)
            send_word(OP_PUT, 32'(i * 7 + 1), $urandom());
        send_word(OP_PUT, 32'h0000_0001, 32'h2);
        random_ops(150, 45);
    endtask

    task automatic test_djb_mode;
        write_hash_mode(1'b1);
        random_ops(250, 40);
    endtask

    // receiver holds off while the sender keeps offering words, then low-byte mode traffic
    task automatic test_backpressure;
        drain();
        hold_cycles = 400;
        random_ops(30, 40);
        drain();
        write_hash_mode(1'b0);
        random_ops(150, 50);
    endtask

    task automatic test_no_idle;
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        random_ops(150, 40);
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        write_hash_mode(1'b1);
        random_ops(120, 35);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        hold_cycles = 0;
        tbl_count = 0;
        hash_sel = 1'b1;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        foreach (tbl_used[i])
            tbl_used[i] = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_low_byte_mode();
        test_djb_mode();
        test_backpressure();
        test_no_idle();
        drain();
        if (mismatches == 0)
            $display("[linear_probe_hash_table] OK");
        else
            $display("[linear_probe_hash_table] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
